// ----- hdl/ec_point_multiple_by_repeated_addition_unit_defines.svh -----
// ---------------------------------------------------------------------------
// EC point multiple unit - assertion macros
// Shared property wrappers for the port-level checker.
// ---------------------------------------------------------------------------
`ifndef EC_POINT_MULTIPLE_BY_REPEATED_ADDITION_UNIT_DEFINES_SVH
`define EC_POINT_MULTIPLE_BY_REPEATED_ADDITION_UNIT_DEFINES_SVH

// Consequent must hold in the cycle after the antecedent.
`define ECPM_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define ECPM_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ----- hdl/ecpm_pkg.sv -----
// ---------------------------------------------------------------------------
// ecpm_pkg
// Types, constants and command encoding for the EC point multiple unit.
// ---------------------------------------------------------------------------
`default_nettype none

package ecpm_pkg;

   localparam int COORD_WIDTH     = 16;
   localparam int COUNT_WIDTH     = 16;
   localparam int PROD_WIDTH      = 2 * COORD_WIDTH;
   localparam int DIV_STEP_WIDTH  = $clog2(PROD_WIDTH);
   localparam int CSR_INDEX_WIDTH = 1;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FIELD_PRIME = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CURVE_A     = 1'b1;

   localparam logic [COORD_WIDTH-1:0] PRIME_RESET   = COORD_WIDTH'(17);
   localparam logic [COORD_WIDTH-1:0] CURVE_A_RESET = COORD_WIDTH'(2);

   localparam logic [COUNT_WIDTH-1:0] MIN_COUNT = COUNT_WIDTH'(3);

   typedef enum logic [1:0] {
      STATUS_NONE     = 2'd0,
      STATUS_VALID    = 2'd1,
      STATUS_INFINITY = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_MOV,
      OP_ADDM,
      OP_SUBM,
      OP_MULM,
      OP_RED,
      OP_DIV,
      OP_EMIT
   } op_type;

   typedef enum logic [4:0] {
      O_ZERO, O_ONE, O_THREE, O_M, O_PX, O_PY, O_CFG_A,
      O_BX, O_BY, O_CX, O_CY, O_A, O_NUM, O_DEN, O_LAM, O_T, O_U,
      O_R0, O_R1, O_T0, O_T1, O_Q, O_REM, O_INV, O_LX, O_LY
   } opnd_type;

   typedef struct packed {
      logic       valid;
      op_type     op;
      opnd_type   dst;
      opnd_type   src1;
      opnd_type   src2;
      status_type status;
   } dp_cmd_type;

   typedef struct packed {
      logic done;
      logic cx_eq_bx;
      logic cy_eq_by;
      logic by_zero;
      logic r1_zero;
      logic r0_one;
      logic rsp_busy;
   } dp_sts_type;

   typedef enum logic [5:0] {
      S_IDLE, S_RED_X, S_RED_Y, S_RED_A, S_INIT_CX, S_INIT_CY, S_CHECK,
      S_DBL1, S_DBL2, S_DBL3, S_DBL4, S_ADD1, S_ADD2,
      S_INV0, S_INV1, S_INV2, S_INV3, S_EUC, S_EUC_DIV, S_EUC_MUL, S_EUC_SUB,
      S_EUC_M1, S_EUC_M2, S_EUC_M3, S_EUC_M4, S_INVF,
      S_LAM, S_SQ, S_NXD1, S_NXD2, S_NXA1, S_NXA2,
      S_NY1, S_NY2, S_NY3, S_NY4, S_NY5, S_NY6, S_EMIT
   } ctrl_state_type;

   function automatic dp_cmd_type mk_cmd(op_type op, opnd_type dst, opnd_type src1,
                                         opnd_type src2, status_type status);
      dp_cmd_type c;
      c.valid  = 1'b1;
      c.op     = op;
      c.dst    = dst;
      c.src1   = src1;
      c.src2   = src2;
      c.status = status;
      return c;
   endfunction

endpackage

`default_nettype wire

// ----- hdl/ecpm_if.sv -----
// ---------------------------------------------------------------------------
// ecpm_if
// Valid/ready channels for base point requests and result transactions.
// ---------------------------------------------------------------------------
`default_nettype none

interface ecpm_req_if;
   import ecpm_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [COORD_WIDTH-1:0] point_x;
   logic [COORD_WIDTH-1:0] point_y;
   logic [COUNT_WIDTH-1:0] multiple_count;
   modport source (output valid, point_x, point_y, multiple_count, input ready);
   modport sink   (input valid, point_x, point_y, multiple_count, output ready);
endinterface

interface ecpm_rsp_if;
   import ecpm_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [COORD_WIDTH-1:0] result_x;
   logic [COORD_WIDTH-1:0] result_y;
   logic [1:0]             status;
   modport source (output valid, result_x, result_y, status, input ready);
   modport sink   (input valid, result_x, result_y, status, output ready);
endinterface

`default_nettype wire

// ----- hdl/ecpm_div.sv -----
// ---------------------------------------------------------------------------
// ecpm_div
// Restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module ecpm_div (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   input  wire logic [ecpm_pkg::PROD_WIDTH-1:0]  dividend,
   input  wire logic [ecpm_pkg::COORD_WIDTH-1:0] divisor,
   output logic                                 done,
   output logic [ecpm_pkg::PROD_WIDTH-1:0]       quotient,
   output logic [ecpm_pkg::COORD_WIDTH-1:0]      remainder
);
   import ecpm_pkg::*;

   logic                      busy_ff;
   logic                      done_ff;
   logic [DIV_STEP_WIDTH-1:0] step_ff;
   logic [PROD_WIDTH-1:0]     quo_ff;
   logic [COORD_WIDTH-1:0]    rem_ff;
   logic [COORD_WIDTH-1:0]    dsr_ff;
   logic [COORD_WIDTH:0]      trial;
   logic [COORD_WIDTH:0]      diff;
   logic                      fits;

   // Trial subtract of the shifted partial remainder
   assign trial = {rem_ff, quo_ff[PROD_WIDTH-1]};
   assign diff  = trial - {1'b0, dsr_ff};
   assign fits  = trial >= {1'b0, dsr_ff};

   // Sequence control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 1'b1;
            if (step_ff == DIV_STEP_WIDTH'(PROD_WIDTH - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Shift one quotient bit in per cycle
   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dsr_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[PROD_WIDTH-2:0], fits};
         rem_ff <= fits ? diff[COORD_WIDTH-1:0] : trial[COORD_WIDTH-1:0];
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

// ----- hdl/ecpm_datapath.sv -----
// ---------------------------------------------------------------------------
// ecpm_datapath
// Working registers, modular add/sub, multiplier and shared divider.
// ---------------------------------------------------------------------------
`default_nettype none

module ecpm_datapath (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_write_enable,
   input  wire logic [ecpm_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [ecpm_pkg::COORD_WIDTH-1:0]     csr_write_data,
   input  wire logic [ecpm_pkg::COORD_WIDTH-1:0]     req_point_x,
   input  wire logic [ecpm_pkg::COORD_WIDTH-1:0]     req_point_y,
   input  wire ecpm_pkg::dp_cmd_type                cmd,
   output ecpm_pkg::dp_sts_type                     sts,
   input  wire logic                                rsp_ready,
   output logic                                     rsp_valid,
   output logic [ecpm_pkg::COORD_WIDTH-1:0]          rsp_result_x,
   output logic [ecpm_pkg::COORD_WIDTH-1:0]          rsp_result_y,
   output logic [1:0]                               rsp_status
);
   import ecpm_pkg::*;

   logic [COORD_WIDTH-1:0] prime_ff, cfg_a_ff, m_ff, px_ff, py_ff;
   logic [COORD_WIDTH-1:0] bx_ff, by_ff, cx_ff, cy_ff, a_ff, num_ff, den_ff, lam_ff;
   logic [COORD_WIDTH-1:0] t_ff, u_ff, r0_ff, r1_ff, t0_ff, t1_ff, q_ff, rem_ff, inv_ff;
   logic [COORD_WIDTH-1:0] lx_ff, ly_ff;
   logic [COORD_WIDTH-1:0] rsp_x_ff, rsp_y_ff;
   logic [1:0]             rsp_status_ff;
   logic                   rsp_valid_ff;
   opnd_type               pend_dst_ff;
   logic                   pend_q_ff;

   logic [COORD_WIDTH-1:0] op1, op2, alu, wr_data, one_m;
   logic [COORD_WIDTH:0]   sum, diff;
   logic [PROD_WIDTH-1:0]  prod, div_dividend, div_quo;
   logic [COORD_WIDTH-1:0] div_divisor, div_rem;
   logic                   div_start, div_done, wr_en, is_div_op;
   opnd_type               wr_sel;

   assign one_m = (m_ff == COORD_WIDTH'(1)) ? '0 : COORD_WIDTH'(1);

   function automatic logic [COORD_WIDTH-1:0] rd(opnd_type sel);
      logic [COORD_WIDTH-1:0] v;
      unique case (sel)
         O_ZERO:  v = '0;
         O_ONE:   v = one_m;
         O_THREE: v = COORD_WIDTH'(3);
         O_M:     v = m_ff;
         O_PX:    v = px_ff;
         O_PY:    v = py_ff;
         O_CFG_A: v = cfg_a_ff;
         O_BX:    v = bx_ff;
         O_BY:    v = by_ff;
         O_CX:    v = cx_ff;
         O_CY:    v = cy_ff;
         O_A:     v = a_ff;
         O_NUM:   v = num_ff;
         O_DEN:   v = den_ff;
         O_LAM:   v = lam_ff;
         O_T:     v = t_ff;
         O_U:     v = u_ff;
         O_R0:    v = r0_ff;
         O_R1:    v = r1_ff;
         O_T0:    v = t0_ff;
         O_T1:    v = t1_ff;
         O_Q:     v = q_ff;
         O_REM:   v = rem_ff;
         O_INV:   v = inv_ff;
         O_LX:    v = lx_ff;
         O_LY:    v = ly_ff;
         default: v = '0;
      endcase
      return v;
   endfunction

   assign op1 = rd(cmd.src1);
   assign op2 = rd(cmd.src2);

   // Modular add and subtract of reduced operands
   always_comb begin
      sum  = {1'b0, op1} + {1'b0, op2};
      diff = {1'b0, op1} - {1'b0, op2};
      if (sum >= {1'b0, m_ff}) sum = sum - {1'b0, m_ff};
      if (op1 < op2) diff = diff + {1'b0, m_ff};
   end

   assign prod = PROD_WIDTH'(op1) * PROD_WIDTH'(op2);

   // Combinational result and divider launch
   always_comb begin
      alu       = op1;
      is_div_op = 1'b0;
      unique case (cmd.op)
         OP_ADDM: alu = sum[COORD_WIDTH-1:0];
         OP_SUBM: alu = diff[COORD_WIDTH-1:0];
         OP_MULM, OP_RED, OP_DIV: is_div_op = 1'b1;
         OP_NONE, OP_LOAD, OP_MOV, OP_EMIT: alu = op1;
         default: alu = op1;
      endcase
      div_start    = cmd.valid && is_div_op;
      div_dividend = (cmd.op == OP_MULM) ? prod : PROD_WIDTH'(op1);
      div_divisor  = (cmd.op == OP_DIV) ? op2 : m_ff;
   end

   ecpm_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // Select the register write of this cycle
   always_comb begin
      wr_en   = 1'b0;
      wr_sel  = cmd.dst;
      wr_data = alu;
      if (div_done) begin
         wr_en   = 1'b1;
         wr_sel  = pend_dst_ff;
         wr_data = div_rem;
      end else if (cmd.valid && (cmd.op == OP_MOV || cmd.op == OP_ADDM ||
                                 cmd.op == OP_SUBM)) begin
         wr_en = 1'b1;
      end
   end

   // Remember where a divider result lands
   always_ff @(posedge clock) begin
      if (div_start) begin
         pend_dst_ff <= cmd.dst;
         pend_q_ff   <= (cmd.op == OP_DIV);
      end
   end

   // Configuration registers and last reported point
   always_ff @(posedge clock) begin
      if (reset) begin
         prime_ff <= PRIME_RESET;
         cfg_a_ff <= CURVE_A_RESET;
         lx_ff    <= '0;
         ly_ff    <= '0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_FIELD_PRIME: prime_ff <= csr_write_data;
               CSR_CURVE_A:     cfg_a_ff <= csr_write_data;
               default:         prime_ff <= prime_ff;
            endcase
         end
         if (wr_en && wr_sel == O_LX) lx_ff <= wr_data;
         if (wr_en && wr_sel == O_LY) ly_ff <= wr_data;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      if (cmd.valid && cmd.op == OP_LOAD) begin
         px_ff <= req_point_x;
         py_ff <= req_point_y;
         m_ff  <= (prime_ff >= COORD_WIDTH'(2)) ? prime_ff : COORD_WIDTH'(1);
      end
      if (div_done && pend_q_ff) q_ff <= div_quo[COORD_WIDTH-1:0];
      if (wr_en) begin
         unique case (wr_sel)
            O_BX:    bx_ff  <= wr_data;
            O_BY:    by_ff  <= wr_data;
            O_CX:    cx_ff  <= wr_data;
            O_CY:    cy_ff  <= wr_data;
            O_A:     a_ff   <= wr_data;
            O_NUM:   num_ff <= wr_data;
            O_DEN:   den_ff <= wr_data;
            O_LAM:   lam_ff <= wr_data;
            O_T:     t_ff   <= wr_data;
            O_U:     u_ff   <= wr_data;
            O_R0:    r0_ff  <= wr_data;
            O_R1:    r1_ff  <= wr_data;
            O_T0:    t0_ff  <= wr_data;
            O_T1:    t1_ff  <= wr_data;
            O_REM:   rem_ff <= wr_data;
            O_INV:   inv_ff <= wr_data;
            default: u_ff   <= u_ff;
         endcase
      end
   end

   // Output register: load on emit, drop on transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.valid && cmd.op == OP_EMIT) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.valid && cmd.op == OP_EMIT) begin
         rsp_x_ff      <= lx_ff;
         rsp_y_ff      <= ly_ff;
         rsp_status_ff <= cmd.status;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_result_x = rsp_x_ff;
   assign rsp_result_y = rsp_y_ff;
   assign rsp_status   = rsp_status_ff;

   assign sts.done     = div_done;
   assign sts.cx_eq_bx = (cx_ff == bx_ff);
   assign sts.cy_eq_by = (cy_ff == by_ff);
   assign sts.by_zero  = (by_ff == '0);
   assign sts.r1_zero  = (r1_ff == '0);
   assign sts.r0_one   = (r0_ff == COORD_WIDTH'(1));
   assign sts.rsp_busy = rsp_valid_ff && !rsp_ready;

endmodule

`default_nettype wire

// ----- hdl/ecpm_ctrl.sv -----
// ---------------------------------------------------------------------------
// ecpm_ctrl
// Sequencer for doubling, repeated addition and extended Euclid inverse.
// ---------------------------------------------------------------------------
`default_nettype none

module ecpm_ctrl (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [ecpm_pkg::COUNT_WIDTH-1:0] req_multiple_count,
   output ecpm_pkg::dp_cmd_type                 cmd,
   input  wire ecpm_pkg::dp_sts_type            sts
);
   import ecpm_pkg::*;

   ctrl_state_type         state_ff, state_in;
   logic                   issued_ff, issued_in;
   logic                   dbl_ff, dbl_in;
   status_type             status_ff, status_in;
   logic [COUNT_WIDTH-1:0] iter_ff, iter_in;

   dp_cmd_type     step_cmd;
   ctrl_state_type step_next;
   logic           step_act, step_multi;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         issued_ff <= 1'b0;
         dbl_ff    <= 1'b0;
         status_ff <= STATUS_NONE;
         iter_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         issued_ff <= issued_in;
         dbl_ff    <= dbl_in;
         status_ff <= status_in;
         iter_ff   <= iter_in;
      end
   end

   // Next state and datapath commands
   always_comb begin
      state_in   = state_ff;
      issued_in  = issued_ff;
      dbl_in     = dbl_ff;
      status_in  = status_ff;
      iter_in    = iter_ff;
      req_ready  = 1'b0;
      cmd        = '0;
      step_act   = 1'b1;
      step_multi = 1'b0;
      step_next  = state_ff;
      step_cmd   = mk_cmd(OP_MOV, O_U, O_U, O_ZERO, status_ff);

      unique case (state_ff)
         S_IDLE: begin
            step_act  = 1'b0;
            req_ready = 1'b1;
            if (req_valid) begin
               cmd     = mk_cmd(OP_LOAD, O_ZERO, O_ZERO, O_ZERO, STATUS_NONE);
               iter_in = req_multiple_count - COUNT_WIDTH'(2);
               if (req_multiple_count < MIN_COUNT) begin
                  status_in = STATUS_NONE;
                  state_in  = S_EMIT;
               end else begin
                  state_in = S_RED_X;
               end
            end
         end
         S_RED_X: begin
            step_cmd = mk_cmd(OP_RED, O_BX, O_PX, O_ZERO, status_ff);
            step_multi = 1'b1; step_next = S_RED_Y;
         end
         S_RED_Y: begin
            step_cmd = mk_cmd(OP_RED, O_BY, O_PY, O_ZERO, status_ff);
            step_multi = 1'b1; step_next = S_RED_A;
         end
         S_RED_A: begin
            step_cmd = mk_cmd(OP_RED, O_A, O_CFG_A, O_ZERO, status_ff);
            step_multi = 1'b1; step_next = S_INIT_CX;
         end
         S_INIT_CX: begin
            step_cmd = mk_cmd(OP_MOV, O_CX, O_BX, O_ZERO, status_ff);
            step_next = S_INIT_CY;
         end
         S_INIT_CY: begin
            step_cmd = mk_cmd(OP_MOV, O_CY, O_BY, O_ZERO, status_ff);
            step_next = S_CHECK;
         end
         // Pick doubling, addition or stop at infinity
         S_CHECK: begin
            step_act = 1'b0;
            dbl_in   = sts.cx_eq_bx;
            if (sts.cx_eq_bx) begin
               if (!sts.cy_eq_by || sts.by_zero) begin
                  status_in = STATUS_INFINITY;
                  state_in  = S_EMIT;
               end else begin
                  state_in = S_DBL1;
               end
            end else begin
               state_in = S_ADD1;
            end
         end
         S_DBL1: begin
            step_cmd = mk_cmd(OP_MULM, O_T, O_BX, O_BX, status_ff);
            step_multi = 1'b1; step_next = S_DBL2;
         end
         S_DBL2: begin
            step_cmd = mk_cmd(OP_MULM, O_T, O_T, O_THREE, status_ff);
            step_multi = 1'b1; step_next = S_DBL3;
         end
         S_DBL3: begin
            step_cmd = mk_cmd(OP_ADDM, O_NUM, O_T, O_A, status_ff);
            step_next = S_DBL4;
         end
         S_DBL4: begin
            step_cmd = mk_cmd(OP_ADDM, O_DEN, O_BY, O_BY, status_ff);
            step_next = S_INV0;
         end
         S_ADD1: begin
            step_cmd = mk_cmd(OP_SUBM, O_NUM, O_CY, O_BY, status_ff);
            step_next = S_ADD2;
         end
         S_ADD2: begin
            step_cmd = mk_cmd(OP_SUBM, O_DEN, O_CX, O_BX, status_ff);
            step_next = S_INV0;
         end
         // Extended Euclid with coefficients kept modulo m
         S_INV0: begin
            step_cmd = mk_cmd(OP_MOV, O_R0, O_M, O_ZERO, status_ff);
            step_next = S_INV1;
         end
         S_INV1: begin
            step_cmd = mk_cmd(OP_MOV, O_R1, O_DEN, O_ZERO, status_ff);
            step_next = S_INV2;
         end
         S_INV2: begin
            step_cmd = mk_cmd(OP_MOV, O_T0, O_ZERO, O_ZERO, status_ff);
            step_next = S_INV3;
         end
         S_INV3: begin
            step_cmd = mk_cmd(OP_MOV, O_T1, O_ONE, O_ZERO, status_ff);
            step_next = S_EUC;
         end
         S_EUC: begin
            step_act = 1'b0;
            state_in = sts.r1_zero ? S_INVF : S_EUC_DIV;
         end
         S_EUC_DIV: begin
            step_cmd = mk_cmd(OP_DIV, O_REM, O_R0, O_R1, status_ff);
            step_multi = 1'b1; step_next = S_EUC_MUL;
         end
         S_EUC_MUL: begin
            step_cmd = mk_cmd(OP_MULM, O_U, O_Q, O_T1, status_ff);
            step_multi = 1'b1; step_next = S_EUC_SUB;
         end
         S_EUC_SUB: begin
            step_cmd = mk_cmd(OP_SUBM, O_U, O_T0, O_U, status_ff);
            step_next = S_EUC_M1;
         end
         S_EUC_M1: begin
            step_cmd = mk_cmd(OP_MOV, O_T0, O_T1, O_ZERO, status_ff);
            step_next = S_EUC_M2;
         end
         S_EUC_M2: begin
            step_cmd = mk_cmd(OP_MOV, O_T1, O_U, O_ZERO, status_ff);
            step_next = S_EUC_M3;
         end
         S_EUC_M3: begin
            step_cmd = mk_cmd(OP_MOV, O_R0, O_R1, O_ZERO, status_ff);
            step_next = S_EUC_M4;
         end
         S_EUC_M4: begin
            step_cmd = mk_cmd(OP_MOV, O_R1, O_REM, O_ZERO, status_ff);
            step_next = S_EUC;
         end
         // No inverse when the gcd is not one
         S_INVF: begin
            step_cmd = mk_cmd(OP_MOV, O_INV, sts.r0_one ? O_T0 : O_ZERO, O_ZERO,
                              status_ff);
            step_next = S_LAM;
         end
         S_LAM: begin
            step_cmd = mk_cmd(OP_MULM, O_LAM, O_NUM, O_INV, status_ff);
            step_multi = 1'b1; step_next = S_SQ;
         end
         S_SQ: begin
            step_cmd = mk_cmd(OP_MULM, O_T, O_LAM, O_LAM, status_ff);
            step_multi = 1'b1; step_next = dbl_ff ? S_NXD1 : S_NXA1;
         end
         S_NXD1: begin
            step_cmd = mk_cmd(OP_ADDM, O_U, O_BX, O_BX, status_ff);
            step_next = S_NXD2;
         end
         S_NXD2: begin
            step_cmd = mk_cmd(OP_SUBM, O_T, O_T, O_U, status_ff);
            step_next = S_NY1;
         end
         S_NXA1: begin
            step_cmd = mk_cmd(OP_SUBM, O_T, O_T, O_BX, status_ff);
            step_next = S_NXA2;
         end
         S_NXA2: begin
            step_cmd = mk_cmd(OP_SUBM, O_T, O_T, O_CX, status_ff);
            step_next = S_NY1;
         end
         S_NY1: begin
            step_cmd = mk_cmd(OP_SUBM, O_U, O_BX, O_T, status_ff);
            step_next = S_NY2;
         end
         S_NY2: begin
            step_cmd = mk_cmd(OP_MULM, O_U, O_LAM, O_U, status_ff);
            step_multi = 1'b1; step_next = S_NY3;
         end
         S_NY3: begin
            step_cmd = mk_cmd(OP_SUBM, O_CY, O_U, O_BY, status_ff);
            step_next = S_NY4;
         end
         S_NY4: begin
            step_cmd = mk_cmd(OP_MOV, O_CX, O_T, O_ZERO, status_ff);
            step_next = S_NY5;
         end
         S_NY5: begin
            step_cmd = mk_cmd(OP_MOV, O_LX, O_CX, O_ZERO, status_ff);
            step_next = S_NY6;
         end
         // Store the new point and count down the group operations
         S_NY6: begin
            step_cmd = mk_cmd(OP_MOV, O_LY, O_CY, O_ZERO, status_ff);
            iter_in  = iter_ff - COUNT_WIDTH'(1);
            if (iter_ff == COUNT_WIDTH'(1)) begin
               status_in = STATUS_VALID;
               step_next = S_EMIT;
            end else begin
               step_next = S_CHECK;
            end
         end
         // Hold until the output register can take the result
         S_EMIT: begin
            step_act = 1'b0;
            if (!sts.rsp_busy) begin
               cmd      = mk_cmd(OP_EMIT, O_ZERO, O_ZERO, O_ZERO, status_ff);
               state_in = S_IDLE;
            end
         end
         default: begin
            step_act = 1'b0;
            state_in = S_IDLE;
         end
      endcase

      // Issue the step; divider steps wait for completion
      if (step_act) begin
         if (!step_multi) begin
            cmd      = step_cmd;
            state_in = step_next;
         end else if (!issued_ff) begin
            cmd       = step_cmd;
            issued_in = 1'b1;
         end else if (sts.done) begin
            issued_in = 1'b0;
            state_in  = step_next;
         end
      end
   end

endmodule

`default_nettype wire

// ----- hdl/ec_point_multiple_by_repeated_addition_unit.sv -----
// ---------------------------------------------------------------------------
// ec_point_multiple_by_repeated_addition_unit
// Forms (count-1)*P on a short Weierstrass curve over a 16-bit prime field.
// ---------------------------------------------------------------------------
//  channel | direction | handshake     | payload
//  req_if  | in        | valid/ready   | point_x, point_y, multiple_count
//  rsp_if  | out       | valid/ready   | result_x, result_y, status
//  csr_*   | in        | write enable  | csr_index, csr_write_data
//
//  One item at a time. Counts below 3 go straight to the result; otherwise the
//  inputs are reduced first, then each group operation (addition or doubling,
//  plus its Euclid rounds) runs every modular reduction on the shared divider.
//  Synchronous active-high reset clears the last point to zero.
//  A finished result waits in the output register; the next request is
//  accepted meanwhile and stalls only at its own result.
// ---------------------------------------------------------------------------
`default_nettype none

module ec_point_multiple_by_repeated_addition_unit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   ecpm_req_if.sink                                 req_if,
   ecpm_rsp_if.source                               rsp_if,
   input  wire logic                                csr_write_enable,
   input  wire logic [ecpm_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [ecpm_pkg::COORD_WIDTH-1:0]     csr_write_data
);
   import ecpm_pkg::*;

   dp_cmd_type cmd;
   dp_sts_type sts;

   ecpm_ctrl u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_if.valid),
      .req_ready          (req_if.ready),
      .req_multiple_count (req_if.multiple_count),
      .cmd                (cmd),
      .sts                (sts)
   );

   ecpm_datapath u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_point_x      (req_if.point_x),
      .req_point_y      (req_if.point_y),
      .cmd              (cmd),
      .sts              (sts),
      .rsp_ready        (rsp_if.ready),
      .rsp_valid        (rsp_if.valid),
      .rsp_result_x     (rsp_if.result_x),
      .rsp_result_y     (rsp_if.result_y),
      .rsp_status       (rsp_if.status)
   );

endmodule

`default_nettype wire

// ----- hdl/ecpm_checker.sv -----
// ---------------------------------------------------------------------------
// ecpm_checker
// Port-level checks of the EC point multiple unit, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "ec_point_multiple_by_repeated_addition_unit_defines.svh"

module ecpm_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [15:0] rsp_result_x,
   input wire logic [1:0]  rsp_status
);
   import ecpm_pkg::*;

   // Hold a stalled result
   `ECPM_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "rsp dropped")
   `ECPM_ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(rsp_result_x), "rsp x moved")
   // One request in flight at a time
   `ECPM_ASSERT_NEXT(a_one_item, req_valid && req_ready, !req_ready, "second request taken")
   // Status code 3 is never reported
   `ECPM_ASSERT_SAME(a_status_code, rsp_valid, rsp_status != 2'd3, "bad status")

endmodule

bind ec_point_multiple_by_repeated_addition_unit ecpm_checker u_ecpm_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_if.valid),
   .req_ready    (req_if.ready),
   .rsp_valid    (rsp_if.valid),
   .rsp_ready    (rsp_if.ready),
   .rsp_result_x (rsp_if.result_x),
   .rsp_status   (rsp_if.status)
);

`default_nettype wire

// ----- verif/ec_point_multiple_by_repeated_addition_unit_tb.sv -----
// ---------------------------------------------------------------------------
// ec_point_multiple_by_repeated_addition_unit_tb
// Drives base points and counts into the point multiple unit through several
// modulus and coefficient settings, predicts each result in a scoreboard
// class and compares it field by field, with random stalls on the result channel
// and random gaps on the request channel.
`default_nettype none

module ec_point_multiple_by_repeated_addition_unit_tb;
   import ecpm_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [COORD_WIDTH-1:0] x;
      logic [COORD_WIDTH-1:0] y;
      status_type             status;
   } point_result_t;

   // Predicts (count-1)*P and holds the expected result transactions
   class point_multiple_predictor;
      longint unsigned prime_reg;
      longint unsigned coef_a;
      longint unsigned held_x;
      longint unsigned held_y;
      point_result_t   expected_points[$];
      int              error_count;
      int              checked_count;
      int              infinity_count;

      function new();
         prime_reg = PRIME_RESET;
         coef_a    = CURVE_A_RESET;
         held_x    = 0;
         held_y    = 0;
      endfunction

      function longint unsigned inverse(longint unsigned v, longint unsigned m);
         longint r0, r1, t0, t1, q, tmp;
         r0 = m;
         r1 = v % m;
         t0 = 0;
         t1 = 1;
         while (r1 != 0) begin
            q   = r0 / r1;
            tmp = r0 - q * r1;
            r0  = r1;
            r1  = tmp;
            tmp = t0 - q * t1;
            t0  = t1;
            t1  = tmp;
         end
         if (r0 != 1) return 0;
         if (t0 < 0) t0 += m;
         return longint'(t0) % m;
      endfunction

      function void note_request(logic [COORD_WIDTH-1:0] px, logic [COORD_WIDTH-1:0] py,
                                 logic [COUNT_WIDTH-1:0] cnt);
         longint unsigned m, bx, by, a, cx, cy, lam, nx, ny, num, den;
         point_result_t   r;
         m  = (prime_reg >= 2) ? prime_reg : 1;
         bx = px % m;
         by = py % m;
         a  = coef_a % m;
         r.status = STATUS_VALID;
         // small count: report the held point, nothing computed
         if (cnt < MIN_COUNT) begin
            r.x = COORD_WIDTH'(held_x);
            r.y = COORD_WIDTH'(held_y);
            r.status = STATUS_NONE;
            expected_points.push_back(r);
            return;
         end
         cx = bx;
         cy = by;
         for (longint unsigned i = 0; i < cnt - 2; i++) begin
            if (cx == bx) begin
               // opposite point or vertical tangent reaches infinity
               if (cy != by || by == 0) begin
                  r.status = STATUS_INFINITY;
                  break;
               end
               num = ((bx * bx % m) * 3 % m + a) % m;
               den = (2 * by) % m;
               lam = num * inverse(den, m) % m;
               nx  = (lam * lam % m + m - (2 * bx) % m) % m;
            end else begin
               num = (cy + m - by) % m;
               den = (cx + m - bx) % m;
               lam = num * inverse(den, m) % m;
               nx  = (lam * lam % m + m - bx) % m;
               nx  = (nx + m - cx) % m;
            end
            ny = ((lam * ((bx + m - nx) % m)) % m + m - by) % m;
            held_x = nx;
            held_y = ny;
            cx = nx;
            cy = ny;
         end
         r.x = COORD_WIDTH'(held_x);
         r.y = COORD_WIDTH'(held_y);
         expected_points.push_back(r);
      endfunction

      function void check_result(logic [COORD_WIDTH-1:0] rx, logic [COORD_WIDTH-1:0] ry,
                                 logic [1:0] st);
         point_result_t e;
         if (expected_points.size() == 0) begin
            $display("%0t: unexpected result x=%0d y=%0d status=%0d", $realtime, rx, ry, st);
            error_count++;
            return;
         end
         e = expected_points.pop_front();
         checked_count++;
         if (e.status == STATUS_INFINITY) infinity_count++;
         if (rx !== e.x) begin
            $display("%0t: result_x expected %0d actual %0d", $realtime, e.x, rx);
            error_count++;
         end
         if (ry !== e.y) begin
            $display("%0t: result_y expected %0d actual %0d", $realtime, e.y, ry);
            error_count++;
         end
         if (st !== e.status) begin
            $display("%0t: status expected %0d actual %0d", $realtime, e.status, st);
            error_count++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [COORD_WIDTH-1:0]     csr_write_data;
   bit   idle_enable;
   int   rsp_stall_left;

   point_multiple_predictor predictor;

   ecpm_req_if req_if ();
   ecpm_rsp_if rsp_if ();

   ec_point_multiple_by_repeated_addition_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_if           (req_if.sink),
      .rsp_if           (rsp_if.source),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hold the run to a fixed budget
   initial begin
      #60_000_000;
      $display("ec_point_multiple_by_repeated_addition_unit_tb: done, errors");
      $finish;
   end

   // Drive result ready with random stall bursts
   initial begin
      rsp_if.ready   = 1'b0;
      rsp_stall_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_stall_left > 0) begin
            rsp_stall_left--;
            rsp_if.ready <= 1'b0;
         end else if (idle_enable && $urandom_range(0, 5) == 0) begin
            rsp_stall_left = $urandom_range(0, 7);
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // Check each result transaction while its fields are stable
   initial begin
      forever begin
         @(negedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready)
            predictor.check_result(rsp_if.result_x, rsp_if.result_y, rsp_if.status);
      end
   end

   task automatic write_register(logic [CSR_INDEX_WIDTH-1:0] idx,
                                 logic [COORD_WIDTH-1:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (idx == CSR_FIELD_PRIME) predictor.prime_reg = value;
      else predictor.coef_a = value;
   endtask

   // Drain all results, then load a new modulus and coefficient
   task automatic set_curve(logic [COORD_WIDTH-1:0] prime, logic [COORD_WIDTH-1:0] a);
      req_if.valid <= 1'b0;
      while (predictor.expected_points.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      write_register(CSR_FIELD_PRIME, prime);
      write_register(CSR_CURVE_A, a);
   endtask

   task automatic send_point(logic [COORD_WIDTH-1:0] px, logic [COORD_WIDTH-1:0] py,
                             logic [COUNT_WIDTH-1:0] cnt);
      bit taken;
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_if.valid          <= 1'b1;
      req_if.point_x        <= px;
      req_if.point_y        <= py;
      req_if.multiple_count <= cnt;
      do begin
         @(negedge clock);
         taken = req_if.ready;
         if (taken) predictor.note_request(px, py, cnt);
         @(posedge clock);
      end while (!taken);
   endtask

   // Random points; counts kept short except where the chain stops at once
   task automatic random_points(int n, int max_count);
      logic [COUNT_WIDTH-1:0] cnt;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 7) == 0) cnt = COUNT_WIDTH'($urandom_range(0, 2));
         else cnt = COUNT_WIDTH'($urandom_range(3, max_count));
         send_point(COORD_WIDTH'($urandom_range(0, 65520)),
                    COORD_WIDTH'($urandom_range(0, 65520)), cnt);
      end
   endtask

   initial begin
      predictor        = new();
      idle_enable      = 1'b1;
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_index        = CSR_FIELD_PRIME;
      csr_write_data   = '0;
      req_if.valid          = 1'b0;
      req_if.point_x        = '0;
      req_if.point_y        = '0;
      req_if.multiple_count = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset curve: small counts, vertical tangent, unreduced inputs
      send_point(16'd5, 16'd1, 16'd0);
      send_point(16'd5, 16'd1, 16'd2);
      send_point(16'd5, 16'd1, 16'd3);
      send_point(16'd5, 16'd1, 16'd1);
      send_point(16'd6, 16'd0, 16'd3);
      send_point(16'd9, 16'd34, 16'd65535);
      send_point(16'd65520, 16'd65520, 16'd3);
      send_point(16'd0, 16'd3, 16'd6);
      send_point(16'd22, 16'd18, 16'd12);

      // Largest prime and coefficient
      set_curve(16'd65521, 16'd65520);
      send_point(16'd65520, 16'd65520, 16'd4);
      send_point(16'd0, 16'd0, 16'd65535);
      send_point(16'd1, 16'd65520, 16'd3);
      random_points(15, 6);

      // Degenerate moduli stop at the first step for any count
      set_curve(16'd0, 16'd0);
      random_points(6, 65535);
      set_curve(16'd1, 16'd65520);
      random_points(6, 65535);

      // Tiny field: chains reach infinity often
      set_curve(16'd7, 16'd3);
      random_points(20, 24);
      set_curve(16'd3, 16'd0);
      random_points(8, 12);

      // Composite modulus where some inverses do not exist
      set_curve(16'd15, 16'd4);
      random_points(10, 10);

      // Mid-size prime, no idling to the end
      set_curve(16'd7919, COORD_WIDTH'($urandom_range(0, 65520)));
      idle_enable = 1'b0;
      random_points(20, 8);
      req_if.valid <= 1'b0;

      while (predictor.expected_points.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("Covered %0d results (%0d at infinity) over eight curve settings.",
               predictor.checked_count, predictor.infinity_count);
      if (predictor.error_count == 0)
         $display("ec_point_multiple_by_repeated_addition_unit_tb: done, clean");
      else
         $display("ec_point_multiple_by_repeated_addition_unit_tb: done, errors");
      $finish;
   end

endmodule

`default_nettype wire
